/* design/rgbc_pkg.sv */
// Shared constants, types and register indexes for the rgb 3x3 convolution block.
// No dependencies; imported by rgbc_filter and rgb_convolution_3x3.
package rgbc_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int COEF_FRAC_DEF = 12;
  localparam int HEIGHT_LIMIT  = 1024;
  localparam int H_W           = $clog2(HEIGHT_LIMIT + 1);
  localparam int DIM_MIN       = 3;
  localparam int CHAN_MAX      = 255;
  localparam int PIX_W         = 24;
  localparam int TAP_W         = 16;
  localparam int ROW_REG_W     = 3 * TAP_W;
  localparam int DIM_REG_W     = 11;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = ROW_REG_W;

  // 455 in each tap, about 1/9 in q4.12
  localparam logic [ROW_REG_W-1:0] KERNEL_RESET = 48'h01C7_01C7_01C7;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 3'd4;

  localparam logic FUNC_PIXEL = 1'b0;

  typedef logic [PIX_W-1:0] pix_t;
  // [row][column], row 0 is the oldest line, column 0 the leftmost
  typedef pix_t [2:0][2:0] win_t;
  typedef logic [2:0][ROW_REG_W-1:0] kernel_t;

  typedef struct packed {
    logic interior;
    logic frame_end;
  } tag_t;

endpackage

/* design/rgbc_ram.sv */
// Generic single-clock RAM, one write port and one read port, registered read.
// Does not import rgbc_pkg; no shared types needed.
module rgbc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/rgbc_filter.sv */
// Filter pipeline: window capture, 27 tap products, row sums, final sum and clamp.
// Depends on rgbc_pkg (win_t, kernel_t, tag_t, TAP_W, CHAN_MAX).
module rgbc_filter
  import rgbc_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  win_t       win_i,
  input  tag_t       tag_i,
  input  kernel_t    kernel_i,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic       frame_end_o
);

  localparam int PROD_W = TAP_W + 9;
  localparam int ROWS_W = PROD_W + 2;
  localparam int ACC_W  = PROD_W + 4;

  logic en2, en3, en4, en_out;

  logic v2_q, v3_q, v4_q, vo_q;
  win_t win2_q;
  tag_t tag2_q, tag3_q, tag4_q;
  pix_t ctr3_q, ctr4_q;

  logic signed [PROD_W-1:0] prod3_d [3][3][3];
  logic signed [PROD_W-1:0] prod3_q [3][3][3];
  logic signed [ROWS_W-1:0] row4_d [3][3];
  logic signed [ROWS_W-1:0] row4_q [3][3];
  logic signed [ACC_W-1:0]  acc    [3];
  logic [2:0][7:0]          res_d;
  logic [2:0][7:0]          res_q;
  logic                     fe_q;

  function automatic logic [7:0] clamp_chan(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] sh;
    logic [7:0] r;
    sh = a >>> COEF_FRAC_BITS;
    if (a < 0) begin
      r = 8'd0;
    end else if (sh > $signed(ACC_W'(CHAN_MAX))) begin
      r = 8'(CHAN_MAX);
    end else begin
      r = sh[7:0];
    end
    return r;
  endfunction

  assign en_out  = !vo_q || ready_i;
  assign en4     = !v4_q || en_out;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign ready_o = en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en2)    v2_q <= valid_i;
      if (en3)    v3_q <= v2_q;
      if (en4)    v4_q <= v3_q;
      if (en_out) vo_q <= v4_q;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod3_d[ch][r][c] = $signed({1'b0, win2_q[r][c][8*ch +: 8]})
                            * $signed(kernel_i[r][TAP_W*c +: TAP_W]);
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        row4_d[ch][r] = ROWS_W'(prod3_q[ch][r][0]) + ROWS_W'(prod3_q[ch][r][1])
                      + ROWS_W'(prod3_q[ch][r][2]);
      end
    end
  end

  // border pixels pass the centre through unchanged
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = ACC_W'(row4_q[ch][0]) + ACC_W'(row4_q[ch][1]) + ACC_W'(row4_q[ch][2]);
      res_d[ch] = tag4_q.interior ? clamp_chan(acc[ch]) : ctr4_q[8*ch +: 8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && valid_i) begin
      win2_q <= win_i;
      tag2_q <= tag_i;
    end
    if (en3 && v2_q) begin
      prod3_q <= prod3_d;
      tag3_q  <= tag2_q;
      ctr3_q  <= win2_q[1][1];
    end
    if (en4 && v3_q) begin
      row4_q <= row4_d;
      tag4_q <= tag3_q;
      ctr4_q <= ctr3_q;
    end
    if (en_out && v4_q) begin
      res_q <= res_d;
      fe_q  <= tag4_q.frame_end;
    end
  end

  assign valid_o     = vo_q;
  assign red_o       = res_q[0];
  assign green_o     = res_q[1];
  assign blue_o      = res_q[2];
  assign frame_end_o = fe_q;

endmodule

/* design/rgb_convolution_3x3.sv */
// Top level of the rgb 3x3 convolution: config registers, raster counters,
// line buffer ram, 3x3 window. Depends on rgbc_pkg, rgbc_ram and rgbc_filter.
//
// Usage: pixels enter in raster order on the in_ channel (func 0), one beat
// per pixel. Each pixel beat from position width+1 onward yields one result
// beat for the position width+1 places behind; after the last pixel of a
// frame, width+1 drain beats (func 1) flush the results still owed. Border
// positions come out unchanged, interior positions filtered per channel.
// frame_end marks the result of the last position of a frame.
// Configuration is a plain write port: cfg_we_i, cfg_idx_i, cfg_data_i.
// Throughput is one beat per clock on both channels; the line buffer ram is
// read at accept and written back when the beat leaves the ram stage, with
// forwarding, so consecutive pixels never wait on it. A result passes through
// ram read, window capture, products, row sums, final sum and clamp. Each
// pipeline stage holds when the next one is full and stalled, so a stalled
// receiver fills the stages before in_ready_o drops. Reset clears counters
// and window, sets the kernel to 1/9 in every tap, the width to MAX_WIDTH
// capped at 1024, the height to 1024; the line buffers need no clearing pass.
module rgb_convolution_3x3
  import rgbc_pkg::*;
#(
  parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic [7:0]            red_in_i,
  input  logic [7:0]            green_in_i,
  input  logic [7:0]            blue_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            red_out_o,
  output logic [7:0]            green_out_o,
  output logic [7:0]            blue_out_o,
  output logic                  frame_end_o
);

  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int PEND_W = $clog2(MAX_WIDTH + 2);
  localparam int LINE_W = 2 * PIX_W;

  // configuration
  kernel_t              kernel_q;
  logic [W_W-1:0]       w_q;
  logic [H_W-1:0]       h_q;
  logic [DIM_REG_W-1:0] dim_raw;

  // raster state
  logic [W_W-1:0]    col_q, col_d;
  logic [H_W-1:0]    row_q, row_d;
  logic [PEND_W-1:0] pend_q, pend_d;

  // front-end decode
  logic              in_acc, is_pix;
  logic [W_W-1:0]    c_n, c_inc, qx;
  logic [H_W-1:0]    r_t, r_n, r_inc, qy;
  logic [PEND_W-1:0] w_p1, pc, k_dr, dr_diff;
  logic              dr_active;
  logic              emit_new, shift_new, write_new, useram_new;
  logic [COL_W-1:0]  addr_new;
  pix_t              pix_new;
  tag_t              tag_new;

  // ram stage
  logic              v1_q, emit1_q, shift1_q, write1_q, useram1_q, fwd_q;
  logic [COL_W-1:0]  addr1_q;
  pix_t              pix1_q;
  tag_t              tag1_q;
  logic [LINE_W-1:0] fwd_data_q;
  logic              en1, leave1;
  logic              ram_we, ram_re, fwd_new;
  logic [LINE_W-1:0] ram_rdata, line, ram_wdata;
  pix_t              col_top, col_mid;

  win_t win_q, win_d;
  logic filt_ready;

  assign in_acc = in_valid_i && in_ready_o;
  assign is_pix = (func_i == FUNC_PIXEL);
  assign dim_raw = cfg_data_i[DIM_REG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q <= {3{KERNEL_RESET}};
      w_q      <= W_W'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);
      h_q      <= H_W'(HEIGHT_LIMIT);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KERNEL_TOP: kernel_q[0] <= cfg_data_i;
        CFG_KERNEL_MID: kernel_q[1] <= cfg_data_i;
        CFG_KERNEL_BOT: kernel_q[2] <= cfg_data_i;
        CFG_WIDTH: begin
          if (int'(dim_raw) < DIM_MIN) begin
            w_q <= W_W'(DIM_MIN);
          end else if (int'(dim_raw) > MAX_WIDTH) begin
            w_q <= W_W'(MAX_WIDTH);
          end else begin
            w_q <= W_W'(dim_raw);
          end
        end
        CFG_HEIGHT: begin
          if (int'(dim_raw) < DIM_MIN) begin
            h_q <= H_W'(DIM_MIN);
          end else if (int'(dim_raw) > HEIGHT_LIMIT) begin
            h_q <= H_W'(HEIGHT_LIMIT);
          end else begin
            h_q <= H_W'(dim_raw);
          end
        end
        default: ;
      endcase
    end
  end

  // position decode; output coordinates follow from the input position,
  // one row and one pixel behind, so no division is needed
  always_comb begin
    c_n = (col_q >= w_q) ? '0 : col_q;
    r_t = (col_q >= w_q) ? row_q + H_W'(1) : row_q;
    r_n = (r_t >= h_q) ? '0 : r_t;
    w_p1 = PEND_W'(w_q) + PEND_W'(1);
    pc = (pend_q > w_p1) ? w_p1 : pend_q;
    c_inc = c_n + W_W'(1);
    r_inc = r_n + H_W'(1);
    k_dr = w_p1 - pc;
    dr_diff = PEND_W'(w_q) - pc;
    dr_active = (c_n == '0) && (r_n == '0);

    col_d = c_n;
    row_d = r_n;
    pend_d = pend_q;
    emit_new = 1'b0;
    shift_new = 1'b0;
    write_new = 1'b0;
    useram_new = 1'b0;
    addr_new = c_n[COL_W-1:0];
    pix_new = {blue_in_i, green_in_i, red_in_i};
    qx = (c_n == '0) ? w_q - W_W'(1) : c_n - W_W'(1);
    qy = (c_n == '0) ? r_n - H_W'(2) : r_n - H_W'(1);

    if (is_pix) begin
      shift_new = 1'b1;
      write_new = 1'b1;
      useram_new = 1'b1;
      emit_new = !((r_n == '0) || ((r_n == H_W'(1)) && (c_n == '0)));
      pend_d = (r_n == '0) ? PEND_W'(c_n) + PEND_W'(1) : w_p1;
      if (c_inc >= w_q) begin
        col_d = '0;
        row_d = (r_inc >= h_q) ? '0 : r_inc;
      end else begin
        col_d = c_inc;
      end
    end else begin
      pix_new = '0;
      addr_new = k_dr[COL_W-1:0];
      if (pc == w_p1) begin
        qx = w_q - W_W'(1);
        qy = h_q - H_W'(2);
      end else begin
        qx = dr_diff[W_W-1:0];
        qy = h_q - H_W'(1);
      end
      if (dr_active) begin
        emit_new = (pc != '0);
        shift_new = (pc != '0);
        useram_new = (pc > PEND_W'(1));
        pend_d = (pc != '0) ? pc - PEND_W'(1) : pc;
      end
    end

    tag_new.interior = (qy >= H_W'(1)) && (qy <= h_q - H_W'(2))
                    && (qx >= W_W'(1)) && (qx <= w_q - W_W'(2));
    tag_new.frame_end = (qy == h_q - H_W'(1)) && (qx == w_q - W_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= '0;
    end else if (in_acc) begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
    end
  end

  // ram stage: a beat leaves when it needs no filter slot or the filter takes it
  assign leave1     = v1_q && (!emit1_q || filt_ready);
  assign en1        = !v1_q || leave1;
  assign in_ready_o = en1;

  assign ram_re    = in_acc && useram_new;
  assign ram_we    = leave1 && write1_q;
  assign fwd_new   = ram_re && ram_we && (addr_new == addr1_q);
  assign line      = fwd_q ? fwd_data_q : ram_rdata;
  assign col_top   = useram1_q ? line[LINE_W-1:PIX_W] : '0;
  assign col_mid   = useram1_q ? line[PIX_W-1:0] : '0;
  // older line takes the newer one, newer line takes the pixel
  assign ram_wdata = {col_mid, pix1_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      emit1_q    <= emit_new;
      shift1_q   <= shift_new;
      write1_q   <= write_new;
      useram1_q  <= useram_new;
      addr1_q    <= addr_new;
      pix1_q     <= pix_new;
      tag1_q     <= tag_new;
      fwd_q      <= fwd_new;
      fwd_data_q <= ram_wdata;
    end
  end

  rgbc_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr1_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(addr_new),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = col_top;
    win_d[1][2] = col_mid;
    win_d[2][2] = pix1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (leave1 && shift1_q) begin
      win_q <= win_d;
    end
  end

  rgbc_filter #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v1_q && emit1_q),
    .ready_o    (filt_ready),
    .win_i      (win_d),
    .tag_i      (tag1_q),
    .kernel_i   (kernel_q),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .red_o      (red_out_o),
    .green_o    (green_out_o),
    .blue_o     (blue_out_o),
    .frame_end_o(frame_end_o)
  );

  // counters stay inside the frame after every pixel beat without a config write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_pix && !cfg_we_i) |=> (col_q < w_q) && (row_q < h_q))
    else $error("raster counters left the frame");

  // results owed never exceed one row plus one pixel after a pixel beat without a config write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_pix && !cfg_we_i) |=> (pend_q <= PEND_W'(w_q) + PEND_W'(1)))
    else $error("pending count above width plus one");

  // a beat that yields a result must move the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && emit1_q) |-> shift1_q)
    else $error("result without window shift");

endmodule
